FILE: rtl/nrtc_pkg.sv
package nrtc_pkg;

  localparam int unsigned PREFIX_LEN      = 6;
  localparam int unsigned TIME_DIGITS     = 6;
  localparam logic [3:0]  COMMAS_REQUIRED = 4'd12;
  localparam logic [3:0]  COMMA_MAX       = 4'd15;
  localparam logic [3:0]  FIELD_IDX_MAX   = 4'd15;
  localparam logic [7:0]  HOURS_PER_DAY   = 8'd24;
  localparam logic [4:0]  HOUR_OFFSET_RST = 5'd8;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_NOT_RMC   = 3'd1;
  localparam logic [2:0] ST_COMMAS    = 3'd2;
  localparam logic [2:0] ST_CHECKSUM  = 3'd3;
  localparam logic [2:0] ST_NO_FIX    = 3'd4;

  typedef struct packed {
    logic                                 prefix_ok;
    logic [3:0]                           comma_count;
    logic [7:0]                           xor_sum;
    logic [7:0]                           received_check;
    logic                                 check_overflow;
    logic                                 fix_seen;
    logic [TIME_DIGITS-1:0][3:0]          time_digits;
  } scan_sum_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = CH_DOLLAR;
      3'd1:    r = CH_G;
      3'd2:    r = CH_P;
      3'd3:    r = CH_R;
      3'd4:    r = CH_M;
      3'd5:    r = CH_C;
      default: r = CH_DOLLAR;
    endcase
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c inside {[CH_A:CH_F]}) begin
      r = {1'b1, 4'(c - CH_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
    logic [6:0] h;
    h = {3'b000, hi};
    return 7'((h << 3) + (h << 1) + {3'b000, lo});
  endfunction

endpackage

FILE: rtl/nrtc_scan.sv
module nrtc_scan
  import nrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_in,
  input  logic       token_end,
  output scan_sum_t  sum
);

  logic [2:0] char_position, char_position_next;
  logic       prefix_ok, prefix_ok_next;
  logic [3:0] comma_count, comma_count_next;
  logic [3:0] field_char_index, field_char_index_next;
  logic [7:0] xor_sum, xor_sum_next;
  logic       in_checksum, in_checksum_next;
  logic [7:0] received_check, received_check_next;
  logic       check_overflow, check_overflow_next;
  logic [TIME_DIGITS-1:0][3:0] time_digits, time_digits_next;
  logic       fix_seen, fix_seen_next;
  logic [4:0] hex;
  logic       is_digit;

  always_comb begin
    char_position_next    = char_position;
    prefix_ok_next        = prefix_ok;
    comma_count_next      = comma_count;
    field_char_index_next = field_char_index;
    xor_sum_next          = xor_sum;
    in_checksum_next      = in_checksum;
    received_check_next   = received_check;
    check_overflow_next   = check_overflow;
    time_digits_next      = time_digits;
    fix_seen_next         = fix_seen;
    hex                   = hex_decode(char_in);
    is_digit              = (char_in >= CH_0) && (char_in <= CH_9);

    if (char_position < 3'(PREFIX_LEN)) begin
      if (char_in != prefix_char(char_position)) begin
        prefix_ok_next = 1'b0;
      end
      char_position_next = char_position + 3'd1;
    end

    if (char_in == CH_COMMA && comma_count != COMMA_MAX) begin
      comma_count_next = comma_count + 4'd1;
    end

    if (char_position != 3'd0 && char_in != CH_STAR && !in_checksum) begin
      xor_sum_next = xor_sum ^ char_in;
    end

    if (comma_count_next == 4'd1 && char_in != CH_COMMA) begin
      if (field_char_index < 4'(TIME_DIGITS)) begin
        time_digits_next[field_char_index[2:0]] = is_digit ? 4'(char_in - CH_0) : 4'd0;
      end
      if (field_char_index != FIELD_IDX_MAX) begin
        field_char_index_next = field_char_index + 4'd1;
      end
    end

    if (comma_count_next == 4'd2 && char_in == CH_A) begin
      fix_seen_next = 1'b1;
    end

    if (in_checksum) begin
      if (hex[4]) begin
        if (received_check[7:4] != 4'd0) begin
          check_overflow_next = 1'b1;
        end
        received_check_next = {received_check[3:0], hex[3:0]};
      end
    end else if (comma_count_next == COMMAS_REQUIRED && char_in == CH_STAR) begin
      in_checksum_next = 1'b1;
    end
  end

  always_comb begin
    sum.prefix_ok      = prefix_ok_next && (char_position_next == 3'(PREFIX_LEN));
    sum.comma_count    = comma_count_next;
    sum.xor_sum        = xor_sum_next;
    sum.received_check = received_check_next;
    sum.check_overflow = check_overflow_next;
    sum.fix_seen       = fix_seen_next;
    sum.time_digits    = time_digits_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && token_end)) begin
      char_position    <= '0;
      prefix_ok        <= 1'b1;
      comma_count      <= '0;
      field_char_index <= '0;
      xor_sum          <= '0;
      in_checksum      <= 1'b0;
      received_check   <= '0;
      check_overflow   <= 1'b0;
      time_digits      <= '0;
      fix_seen         <= 1'b0;
    end else if (step) begin
      char_position    <= char_position_next;
      prefix_ok        <= prefix_ok_next;
      comma_count      <= comma_count_next;
      field_char_index <= field_char_index_next;
      xor_sum          <= xor_sum_next;
      in_checksum      <= in_checksum_next;
      received_check   <= received_check_next;
      check_overflow   <= check_overflow_next;
      time_digits      <= time_digits_next;
      fix_seen         <= fix_seen_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step && token_end |=> char_position == 3'd0 && comma_count == 4'd0 && !in_checksum)
    else $error("token state not cleared after end of token");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    char_position <= 3'(PREFIX_LEN))
    else $error("char position past prefix length");

endmodule

FILE: rtl/nrtc_report.sv
module nrtc_report
  import nrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       report,
  input  scan_sum_t  sum,
  input  logic [4:0] hour_offset,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [2:0] sentence_status,
  output logic [4:0] held_hours,
  output logic [6:0] held_minutes,
  output logic [6:0] held_seconds
);

  logic [2:0] status_next;
  logic [6:0] utc_hours;
  logic [7:0] hour_sum;
  logic [7:0] hour_wrap;

  always_comb begin
    utc_hours = two_digits(sum.time_digits[0], sum.time_digits[1]);
    hour_sum  = {1'b0, utc_hours} + {3'b000, hour_offset};
    hour_wrap = hour_sum;
    for (int i = 1; i <= 5; i++) begin
      if (hour_sum >= 8'(i) * HOURS_PER_DAY) begin
        hour_wrap = hour_sum - 8'(i) * HOURS_PER_DAY;
      end
    end

    if (!sum.prefix_ok) begin
      status_next = ST_NOT_RMC;
    end else if (sum.comma_count != COMMAS_REQUIRED) begin
      status_next = ST_COMMAS;
    end else if (sum.check_overflow || sum.xor_sum != sum.received_check) begin
      status_next = ST_CHECKSUM;
    end else if (!sum.fix_seen) begin
      status_next = ST_NO_FIX;
    end else begin
      status_next = ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      sentence_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_hours   <= '0;
      held_minutes <= '0;
      held_seconds <= '0;
    end else if (report && status_next == ST_ACCEPTED) begin
      held_hours   <= hour_wrap[4:0];
      held_minutes <= two_digits(sum.time_digits[2], sum.time_digits[3]);
      held_seconds <= two_digits(sum.time_digits[4], sum.time_digits[5]);
    end
  end

  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    held_hours < 5'd24)
    else $error("held hours out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !report)
    else $error("pending result overwritten");

  a_held_on_reject: assert property (@(posedge clk) disable iff (rst)
    report && status_next != ST_ACCEPTED |=> $stable(held_hours) && $stable(held_minutes))
    else $error("held time changed on rejected sentence");

endmodule

FILE: rtl/nmea_rmc_time_checker.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  hour_offset
// in        in         in_valid / in_ready    char_in, token_end
// out       out        out_valid / out_ready  sentence_status, held_hours/minutes/seconds
//
// One word per cycle sustained; a word is registered, then folded into the
// token state by combinational logic, and the result is registered at the output.
// Synchronous reset clears token state, held time and sets hour_offset to 8.
// Only a token-end word stalls, and only while the output register holds an untaken result.
// cfg_ready is always high.
module nmea_rmc_time_checker
  import nrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] hour_offset,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       token_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] sentence_status,
  output logic [4:0] held_hours,
  output logic [6:0] held_minutes,
  output logic [6:0] held_seconds
);

  logic       in_full;
  logic [7:0] char_q;
  logic       end_q;
  logic       step;
  logic       report;
  logic [4:0] offset;
  scan_sum_t  sum;

  assign cfg_ready = 1'b1;
  assign step      = in_full && (!end_q || !out_valid || out_ready);
  assign report    = step && end_q;
  assign in_ready  = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= HOUR_OFFSET_RST;
    end else if (cfg_valid) begin
      offset <= hour_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_in;
      end_q  <= token_end;
    end
  end

  nrtc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_in   (char_q),
    .token_end (end_q),
    .sum       (sum)
  );

  nrtc_report u_report (
    .clk             (clk),
    .rst             (rst),
    .report          (report),
    .sum             (sum),
    .hour_offset     (offset),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .sentence_status (sentence_status),
    .held_hours      (held_hours),
    .held_minutes    (held_minutes),
    .held_seconds    (held_seconds)
  );

  a_mid_token_flows: assert property (@(posedge clk) disable iff (rst)
    in_full && !end_q |-> in_ready)
    else $error("mid-token word stalled");

  a_report_sets_valid: assert property (@(posedge clk) disable iff (rst)
    report |=> out_valid)
    else $error("result not presented after token end");

endmodule
